// ----- hw/rtl/tgc_pkg.sv -----
package tgc_pkg;

	localparam int RAW_W   = 12;
	localparam int COORD_W = 8;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 16;
	localparam int DRIFT_W = 9;

	localparam logic [RAW_W-1:0] SCREEN_SIZE = 12'd240;
	localparam logic [RAW_W-1:0] SCREEN_MAX  = SCREEN_SIZE - 12'd1;
	localparam logic [RAW_W-1:0] RAW_LIMIT   = 12'd500;
	localparam logic [RAW_W-1:0] X_OFFSET    = 12'h0FF;

	localparam logic [3:0] FINGERS_MIN = 4'd1;
	localparam logic [3:0] FINGERS_MAX = 4'd2;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t CFG_LONG_PRESS_TIME = 3'd0;
	localparam cfg_index_t CFG_TAP_DRIFT_LIMIT = 3'd1;
	localparam cfg_index_t CFG_SWIPE_DISTANCE  = 3'd2;
	localparam cfg_index_t CFG_RELEASE_TIMEOUT = 3'd3;
	localparam cfg_index_t CFG_DEBOUNCE_TIME   = 3'd4;

	typedef enum logic [2:0] {
		GEST_TAP        = 3'd0,
		GEST_LONG_PRESS = 3'd1,
		GEST_SWIPE_UP   = 3'd2,
		GEST_SWIPE_DOWN = 3'd3,
		GEST_SWIPE_LEFT = 3'd4,
		GEST_SWIPE_RIGHT = 3'd5
	} gesture_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_ms;
		logic              expander_line;
		logic              irq_seen;
		logic              read_ok;
		logic [7:0]        finger_byte;
		logic [7:0]        x_high;
		logic [7:0]        x_low;
		logic [7:0]        y_high;
		logic [7:0]        y_low;
	} poll_t;

	typedef struct packed {
		logic               ok;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} sample_t;

	typedef struct packed {
		gesture_t           gesture;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [TIME_W-1:0]  duration;
	} result_t;

endpackage

// ----- hw/rtl/tgc_if.sv -----
interface tgc_poll_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_ms;
	logic        expander_line;
	logic        irq_seen;
	logic        read_ok;
	logic [7:0]  finger_byte;
	logic [7:0]  x_high;
	logic [7:0]  x_low;
	logic [7:0]  y_high;
	logic [7:0]  y_low;

	modport source (
		output valid, time_ms, expander_line, irq_seen, read_ok,
		output finger_byte, x_high, x_low, y_high, y_low,
		input  ready
	);
	modport sink (
		input  valid, time_ms, expander_line, irq_seen, read_ok,
		input  finger_byte, x_high, x_low, y_high, y_low,
		output ready
	);
endinterface

interface tgc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  gesture;
	logic [7:0]  pos_x;
	logic [7:0]  pos_y;
	logic [31:0] duration;

	modport source (
		output valid, gesture, pos_x, pos_y, duration,
		input  ready
	);
	modport sink (
		input  valid, gesture, pos_x, pos_y, duration,
		output ready
	);
endinterface

// ----- hw/rtl/tgc_sample.sv -----
module tgc_sample (
	input  tgc_pkg::poll_t   poll,
	output tgc_pkg::sample_t sample
);
	import tgc_pkg::*;

	logic [RAW_W-1:0] raw_x;
	logic [RAW_W-1:0] raw_y;
	logic [RAW_W-1:0] m;
	logic [RAW_W-1:0] y_full;
	logic [3:0]       fingers;

	assign fingers = poll.finger_byte[3:0];
	assign raw_x   = {poll.x_high[3:0], poll.x_low};
	assign raw_y   = {poll.y_high[3:0], poll.y_low};
	assign m       = X_OFFSET - raw_x;
	assign y_full  = SCREEN_MAX - m;

	assign sample.ok = poll.read_ok
		&& fingers >= FINGERS_MIN && fingers <= FINGERS_MAX
		&& raw_x <= RAW_LIMIT && raw_y <= RAW_LIMIT
		&& raw_y < SCREEN_SIZE && m <= SCREEN_MAX;
	assign sample.x  = raw_y[COORD_W-1:0];
	assign sample.y  = y_full[COORD_W-1:0];
endmodule

// ----- hw/rtl/touch_gesture_classifier.sv -----
// Touch gesture classifier: turns touch controller polls into tap, long press
// and four-way swipe items.
// poll channel (valid/ready): one item per poll with the time stamp, interrupt
// indications and raw coordinate bytes. result channel (valid/ready): zero or
// one gesture item per poll. Config: write cfg_wdata to register cfg_index
// while cfg_we is high; write only while no item is in flight.
// Timing: a poll is registered at acceptance and evaluated in the next cycle;
// its gesture (if any) is registered at the end of that cycle unless a stall
// holds it. Throughput: one poll per cycle unless stalled; the single
// evaluation stage between the input register and the result register sets it.
// Reset: clears the touch state and loads the default timing and drift limits.
// Stall: a waiting result holds in the result register; polls that produce no
// gesture keep flowing, and a poll that would produce one waits in the input
// register until the result is taken.
module touch_gesture_classifier (
	input  logic                           clk,
	input  logic                           arst_n,
	tgc_poll_if.sink                       poll,
	tgc_result_if.source                   result,
	input  logic                           cfg_we,
	input  tgc_pkg::cfg_index_t            cfg_index,
	input  logic [tgc_pkg::CFG_W-1:0]      cfg_wdata
);
	import tgc_pkg::*;

	logic [15:0]        long_press_time_q;
	logic [8:0]         tap_drift_limit_q;
	logic [8:0]         swipe_distance_q;
	logic [15:0]        release_timeout_q;
	logic [15:0]        debounce_time_q;

	logic               pressed_q;
	logic               long_done_q;
	logic               pending_q;
	logic [TIME_W-1:0]  press_time_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [COORD_W-1:0] start_x_q;
	logic [COORD_W-1:0] start_y_q;
	logic [COORD_W-1:0] now_x_q;
	logic [COORD_W-1:0] now_y_q;

	logic               valid_s1;
	poll_t              poll_s1;
	poll_t              poll_in;
	sample_t            sample;

	logic               out_valid_q;
	result_t            res_q;

	logic [TIME_W-1:0]  held;
	logic [TIME_W-1:0]  idle;
	logic [COORD_W-1:0] adx;
	logic [COORD_W-1:0] ady;
	logic [DRIFT_W-1:0] drift;
	logic               pending_next;
	logic               long_fire;
	logic               rel;
	logic               rel_emit;
	logic               emit;
	logic               s1_fire;
	result_t            res_d;

	assign poll_in.time_ms       = poll.time_ms;
	assign poll_in.expander_line = poll.expander_line;
	assign poll_in.irq_seen      = poll.irq_seen;
	assign poll_in.read_ok       = poll.read_ok;
	assign poll_in.finger_byte   = poll.finger_byte;
	assign poll_in.x_high        = poll.x_high;
	assign poll_in.x_low         = poll.x_low;
	assign poll_in.y_high        = poll.y_high;
	assign poll_in.y_low         = poll.y_low;

	tgc_sample u_sample (
		.poll   (poll_s1),
		.sample (sample)
	);

	always_comb begin
		held  = poll_s1.time_ms - press_time_q;
		idle  = poll_s1.time_ms - last_time_q;
		adx   = (now_x_q > start_x_q) ? now_x_q - start_x_q : start_x_q - now_x_q;
		ady   = (now_y_q > start_y_q) ? now_y_q - start_y_q : start_y_q - now_y_q;
		drift = {1'b0, adx} + {1'b0, ady};

		pending_next = pending_q || !poll_s1.expander_line || poll_s1.irq_seen;
		long_fire = pressed_q && !long_done_q
			&& held >= {16'd0, long_press_time_q} && drift <= tap_drift_limit_q;
		rel = pressed_q && !sample.ok && idle >= {16'd0, release_timeout_q};
		rel_emit = rel && !long_done_q && !long_fire
			&& held >= {16'd0, debounce_time_q};
		emit = long_fire || rel_emit;

		res_d.duration = held;
		res_d.pos_x    = start_x_q;
		res_d.pos_y    = start_y_q;
		res_d.gesture  = GEST_TAP;
		priority if (long_fire) begin
			res_d.gesture = GEST_LONG_PRESS;
		end else if (drift >= swipe_distance_q) begin
			res_d.pos_x = now_x_q;
			res_d.pos_y = now_y_q;
			if (adx > ady) begin
				res_d.gesture = (now_x_q > start_x_q) ? GEST_SWIPE_RIGHT : GEST_SWIPE_LEFT;
			end else begin
				res_d.gesture = (now_y_q > start_y_q) ? GEST_SWIPE_DOWN : GEST_SWIPE_UP;
			end
		end else begin
			res_d.gesture = GEST_TAP;
		end
	end

	assign s1_fire    = valid_s1 && (!emit || !out_valid_q || result.ready);
	assign poll.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_time_q <= 16'd400;
			tap_drift_limit_q <= 9'd35;
			swipe_distance_q  <= 9'd40;
			release_timeout_q <= 16'd120;
			debounce_time_q   <= 16'd20;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LONG_PRESS_TIME: long_press_time_q <= cfg_wdata;
				CFG_TAP_DRIFT_LIMIT: tap_drift_limit_q <= cfg_wdata[8:0];
				CFG_SWIPE_DISTANCE:  swipe_distance_q  <= cfg_wdata[8:0];
				CFG_RELEASE_TIMEOUT: release_timeout_q <= cfg_wdata;
				CFG_DEBOUNCE_TIME:   debounce_time_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			poll_s1 <= poll_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q    <= 1'b0;
			long_done_q  <= 1'b0;
			pending_q    <= 1'b0;
			press_time_q <= '0;
			last_time_q  <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			now_x_q      <= '0;
			now_y_q      <= '0;
		end else if (s1_fire) begin
			if (pressed_q) begin
				pending_q <= pending_next;
				if (long_fire) begin
					long_done_q <= 1'b1;
				end
				if (sample.ok) begin
					now_x_q     <= sample.x;
					now_y_q     <= sample.y;
					last_time_q <= poll_s1.time_ms;
				end else if (rel) begin
					pressed_q <= 1'b0;
				end
			end else if (pending_next) begin
				pending_q <= 1'b0;
				if (sample.ok) begin
					pressed_q    <= 1'b1;
					long_done_q  <= 1'b0;
					press_time_q <= poll_s1.time_ms;
					last_time_q  <= poll_s1.time_ms;
					start_x_q    <= sample.x;
					start_y_q    <= sample.y;
					now_x_q      <= sample.x;
					now_y_q      <= sample.y;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && emit) begin
			res_q <= res_d;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.gesture  = res_q.gesture;
	assign result.pos_x    = res_q.pos_x;
	assign result.pos_y    = res_q.pos_y;
	assign result.duration = res_q.duration;
endmodule

// ----- tb/sv/touch_gesture_checker.sv -----
`timescale 1ns / 1ps

module touch_gesture_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	tgc_poll_if                       poll,
	tgc_result_if                     result,
	input  logic                      cfg_we,
	input  tgc_pkg::cfg_index_t       cfg_index,
	input  logic [tgc_pkg::CFG_W-1:0] cfg_wdata,
	output int                        mismatches,
	output int                        gestures_due
);
	import tgc_pkg::*;

	logic [15:0] hold_limit;
	logic [8:0]  still_limit;
	logic [8:0]  swipe_min;
	logic [15:0] lift_timeout;
	logic [15:0] bounce_limit;

	bit          pressed;
	bit          long_done;
	bit          touch_pending;
	logic [31:0] press_t;
	logic [31:0] last_seen_t;
	logic [7:0]  start_x;
	logic [7:0]  start_y;
	logic [7:0]  cur_x;
	logic [7:0]  cur_y;

	result_t     gesture_q[$];
	int          fail_count;

	function automatic int span(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? int'(a - b) : int'(b - a);
	endfunction

	function automatic bit classify_poll(input poll_t p, output result_t g);
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [11:0] m;
		logic [7:0]  sx;
		logic [7:0]  sy;
		logic [31:0] held;
		logic [31:0] dur;
		int          dx;
		int          dy;
		bit          sample_ok;
		bit          fired;
		fired = 1'b0;
		g = '0;
		if (!p.expander_line || p.irq_seen) begin
			touch_pending = 1'b1;
		end
		raw_x = {p.x_high[3:0], p.x_low};
		raw_y = {p.y_high[3:0], p.y_low};
		m = X_OFFSET - raw_x;
		sx = raw_y[7:0];
		sy = 8'(SCREEN_MAX - m);
		sample_ok = p.read_ok && p.finger_byte[3:0] >= FINGERS_MIN &&
			p.finger_byte[3:0] <= FINGERS_MAX && raw_x <= RAW_LIMIT &&
			raw_y <= RAW_LIMIT && raw_y < SCREEN_SIZE && m <= SCREEN_MAX;

		if (pressed) begin
			if (!long_done) begin
				held = p.time_ms - press_t;
				if (held >= 32'(hold_limit) &&
					span(cur_x, start_x) + span(cur_y, start_y) <= int'(still_limit)) begin
					long_done = 1'b1;
					g = '{GEST_LONG_PRESS, start_x, start_y, held};
					fired = 1'b1;
				end
			end
			if (sample_ok) begin
				cur_x = sx;
				cur_y = sy;
				last_seen_t = p.time_ms;
			end else if (p.time_ms - last_seen_t >= 32'(lift_timeout)) begin
				dur = p.time_ms - press_t;
				pressed = 1'b0;
				if (!long_done && dur >= 32'(bounce_limit)) begin
					dx = span(cur_x, start_x);
					dy = span(cur_y, start_y);
					if (dx + dy >= int'(swipe_min)) begin
						if (dx > dy) begin
							g.gesture = (cur_x > start_x) ? GEST_SWIPE_RIGHT : GEST_SWIPE_LEFT;
						end else begin
							g.gesture = (cur_y > start_y) ? GEST_SWIPE_DOWN : GEST_SWIPE_UP;
						end
						g.pos_x = cur_x;
						g.pos_y = cur_y;
						g.duration = dur;
					end else begin
						g = '{GEST_TAP, start_x, start_y, dur};
					end
					fired = 1'b1;
				end
				return fired;
			end
		end

		if (!pressed && touch_pending) begin
			touch_pending = 1'b0;
			if (sample_ok) begin
				pressed = 1'b1;
				press_t = p.time_ms;
				start_x = sx;
				start_y = sy;
				cur_x = sx;
				cur_y = sy;
				last_seen_t = p.time_ms;
				long_done = 1'b0;
			end
		end
		return fired;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		poll_t   p;
		result_t want;
		if (!arst_n) begin
			hold_limit = 16'd400;
			still_limit = 9'd35;
			swipe_min = 9'd40;
			lift_timeout = 16'd120;
			bounce_limit = 16'd20;
			pressed = 1'b0;
			long_done = 1'b0;
			touch_pending = 1'b0;
			press_t = '0;
			last_seen_t = '0;
			start_x = '0;
			start_y = '0;
			cur_x = '0;
			cur_y = '0;
			gesture_q.delete();
			fail_count = 0;
			mismatches <= 0;
			gestures_due <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (gesture_q.size() == 0) begin
					$display("%0t: gesture expected none actual %0d at (%0d,%0d) after %0d ms",
						$time, result.gesture, result.pos_x, result.pos_y, result.duration);
					fail_count++;
				end else begin
					want = gesture_q.pop_front();
					if (result.gesture !== want.gesture) begin
						$display("%0t: gesture expected %0d actual %0d",
							$time, want.gesture, result.gesture);
						fail_count++;
					end
					if (result.pos_x !== want.pos_x) begin
						$display("%0t: pos_x expected %0d actual %0d",
							$time, want.pos_x, result.pos_x);
						fail_count++;
					end
					if (result.pos_y !== want.pos_y) begin
						$display("%0t: pos_y expected %0d actual %0d",
							$time, want.pos_y, result.pos_y);
						fail_count++;
					end
					if (result.duration !== want.duration) begin
						$display("%0t: duration expected %0d actual %0d",
							$time, want.duration, result.duration);
						fail_count++;
					end
				end
			end
			if (poll.valid && poll.ready) begin
				p = {poll.time_ms, poll.expander_line, poll.irq_seen, poll.read_ok,
					poll.finger_byte, poll.x_high, poll.x_low, poll.y_high, poll.y_low};
				if (classify_poll(p, want)) begin
					gesture_q.push_back(want);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_LONG_PRESS_TIME: hold_limit = cfg_wdata[15:0];
					CFG_TAP_DRIFT_LIMIT: still_limit = cfg_wdata[8:0];
					CFG_SWIPE_DISTANCE:  swipe_min = cfg_wdata[8:0];
					CFG_RELEASE_TIMEOUT: lift_timeout = cfg_wdata[15:0];
					CFG_DEBOUNCE_TIME:   bounce_limit = cfg_wdata[15:0];
					default: ;
				endcase
			end
			mismatches <= fail_count;
			gestures_due <= gesture_q.size();
		end
	end

endmodule

// ----- tb/sv/touch_gesture_classifier_tb.sv -----
`timescale 1ns / 1ps

module touch_gesture_classifier_tb;
	import tgc_pkg::*;

	localparam int ITEM_TARGET  = 450;
	localparam int PHASES       = 6;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	cfg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	int          mismatches;
	int          gestures_due;
	int          idle_cycles = 0;
	int          src_idle_pct;
	int          sink_stall_pct;
	int          sink_hold = 0;
	int          polls_sent;
	int          phase;
	int          phase_end;
	logic [31:0] clock_ms;

	int reg_hold;
	int reg_still;
	int reg_timeout;
	int reg_bounce;

	tgc_poll_if   poll_ch ();
	tgc_result_if result_ch ();

	touch_gesture_classifier u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	touch_gesture_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.poll         (poll_ch),
		.result       (result_ch),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.gestures_due (gestures_due)
	);

	always #10 clk = ~clk;

	function automatic int pause_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(1, 3);
		if (roll < 95) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int clamp_px(input int v);
		if (v < 0) return 0;
		if (v > 239) return 239;
		return v;
	endfunction

	function automatic poll_t touch_sample(input logic [31:0] t, input int x, input int y,
		input bit line, input bit irq);
		poll_t       p;
		logic [11:0] raw_x;
		raw_x = 12'(y + 16);
		p.time_ms = t;
		p.expander_line = line;
		p.irq_seen = irq;
		p.read_ok = 1'b1;
		p.finger_byte = {4'($urandom), 4'($urandom_range(1, 2))};
		p.x_high = {4'($urandom), raw_x[11:8]};
		p.x_low = raw_x[7:0];
		p.y_high = {4'($urandom), 4'h0};
		p.y_low = 8'(x);
		return p;
	endfunction

	function automatic poll_t noise_sample(input logic [31:0] t);
		poll_t       p;
		logic [95:0] bits;
		bits = {$urandom, $urandom, $urandom};
		p = bits[$bits(poll_t)-1:0];
		p.time_ms = t;
		return p;
	endfunction

	function automatic poll_t lift_sample(input logic [31:0] t);
		poll_t       p;
		logic [11:0] raw;
		p = noise_sample(t);
		case ($urandom_range(0, 5))
			0: p.read_ok = 1'b0;
			1: p.finger_byte[3:0] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(3, 15));
			2: p.x_high[3:0] = 4'($urandom_range(2, 15));
			3: p.y_high[3:0] = 4'($urandom_range(2, 15));
			4: begin
				raw = $urandom_range(0, 1) ? 12'($urandom_range(0, 15)) :
					12'($urandom_range(256, 500));
				p.x_high[3:0] = raw[11:8];
				p.x_low = raw[7:0];
			end
			default: begin
				raw = 12'($urandom_range(240, 500));
				p.y_high[3:0] = raw[11:8];
				p.y_low = raw[7:0];
			end
		endcase
		return p;
	endfunction

	task automatic send_poll(input poll_t p);
		int gap;
		gap = ($urandom_range(0, 99) < src_idle_pct) ? pause_len() : 0;
		if (gap > 0) begin
			poll_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		poll_ch.valid         <= 1'b1;
		poll_ch.time_ms       <= p.time_ms;
		poll_ch.expander_line <= p.expander_line;
		poll_ch.irq_seen      <= p.irq_seen;
		poll_ch.read_ok       <= p.read_ok;
		poll_ch.finger_byte   <= p.finger_byte;
		poll_ch.x_high        <= p.x_high;
		poll_ch.x_low         <= p.x_low;
		poll_ch.y_high        <= p.y_high;
		poll_ch.y_low         <= p.y_low;
		@(posedge clk);
		while (!poll_ch.ready) @(posedge clk);
		polls_sent++;
	endtask

	task automatic settle();
		poll_ch.valid <= 1'b0;
		@(posedge clk);
		while (gestures_due != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input int hold, input int still, input int swipe,
		input int lift, input int bounce);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_LONG_PRESS_TIME;
		cfg_wdata <= CFG_W'(hold);
		@(posedge clk);
		cfg_index <= CFG_TAP_DRIFT_LIMIT;
		cfg_wdata <= CFG_W'(still);
		@(posedge clk);
		cfg_index <= CFG_SWIPE_DISTANCE;
		cfg_wdata <= CFG_W'(swipe);
		@(posedge clk);
		cfg_index <= CFG_RELEASE_TIMEOUT;
		cfg_wdata <= CFG_W'(lift);
		@(posedge clk);
		cfg_index <= CFG_DEBOUNCE_TIME;
		cfg_wdata <= CFG_W'(bounce);
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_hold = hold;
		reg_still = still;
		reg_timeout = lift;
		reg_bounce = bounce;
	endtask

	task automatic run_gesture();
		int          kind;
		int          steps;
		int          lifts;
		int          i;
		int          x0;
		int          y0;
		int          x1;
		int          y1;
		int          w;
		logic [31:0] span_ms;
		logic [31:0] t0;
		logic [31:0] t;
		kind = $urandom_range(0, 9);
		x0 = $urandom_range(0, 239);
		y0 = $urandom_range(0, 239);
		x1 = x0;
		y1 = y0;
		if (kind < 3) begin
			x1 = $urandom_range(0, 239);
			y1 = $urandom_range(0, 239);
			span_ms = $urandom_range(0, reg_bounce + 300);
		end else if (kind < 5) begin
			w = reg_still / 2;
			x1 = clamp_px(x0 + $urandom_range(0, 2 * w) - w);
			y1 = clamp_px(y0 + $urandom_range(0, 2 * w) - w);
			span_ms = reg_hold + $urandom_range(0, 100);
		end else if (kind < 8) begin
			x1 = clamp_px(x0 + $urandom_range(0, 50) - 25);
			y1 = clamp_px(y0 + $urandom_range(0, 50) - 25);
			span_ms = $urandom_range(0, 2 * reg_bounce + 100);
		end else if (kind == 8) begin
			x1 = $urandom_range(0, 239);
			y1 = $urandom_range(0, 239);
			span_ms = reg_hold + $urandom_range(0, 200);
		end else begin
			span_ms = $urandom_range(0, reg_bounce);
		end

		steps = $urandom_range(1, 5);
		t0 = clock_ms;
		for (i = 0; i <= steps; i++) begin
			t = t0 + span_ms * i / steps;
			if ($urandom_range(0, 9) == 0) begin
				send_poll(lift_sample(t));
			end
			send_poll(touch_sample(t, x0 + (x1 - x0) * i / steps, y0 + (y1 - y0) * i / steps,
				(i == 0) ? ($urandom_range(0, 9) == 0) : 1'($urandom), 1'($urandom)));
		end

		lifts = $urandom_range(1, 3);
		for (i = 1; i < lifts; i++) begin
			send_poll(lift_sample(t + 32'(reg_timeout * i / lifts)));
		end
		t = t + 32'(reg_timeout) + $urandom_range(0, 5);
		send_poll(lift_sample(t));
		clock_ms = t + $urandom_range(1, 50);
	endtask

	always @(posedge clk) begin
		if (sink_hold > 0) begin
			result_ch.ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else if ($urandom_range(0, 99) < sink_stall_pct) begin
			result_ch.ready <= 1'b0;
			sink_hold <= pause_len();
		end else begin
			result_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LONG_PRESS_TIME;
		cfg_wdata = '0;
		poll_ch.valid = 1'b0;
		poll_ch.time_ms = '0;
		poll_ch.expander_line = 1'b1;
		poll_ch.irq_seen = 1'b0;
		poll_ch.read_ok = 1'b0;
		poll_ch.finger_byte = '0;
		poll_ch.x_high = '0;
		poll_ch.x_low = '0;
		poll_ch.y_high = '0;
		poll_ch.y_low = '0;
		polls_sent = 0;
		src_idle_pct = 20;
		sink_stall_pct = 20;
		reg_hold = 400;
		reg_still = 35;
		reg_timeout = 120;
		reg_bounce = 20;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tap in the top left corner
		send_poll(touch_sample(32'd1000, 0, 0, 1'b0, 1'b0));
		send_poll(touch_sample(32'd1010, 0, 0, 1'b1, 1'b1));
		send_poll(lift_sample(32'd1130));
		// swipe right, left, down and up along the screen edges
		send_poll(touch_sample(32'd2000, 0, 0, 1'b0, 1'b0));
		send_poll(touch_sample(32'd2050, 239, 0, 1'b1, 1'b0));
		send_poll(lift_sample(32'd2170));
		send_poll(touch_sample(32'd3000, 239, 239, 1'b1, 1'b1));
		send_poll(touch_sample(32'd3050, 0, 239, 1'b1, 1'b0));
		send_poll(lift_sample(32'd3170));
		send_poll(touch_sample(32'd4000, 0, 0, 1'b0, 1'b1));
		send_poll(touch_sample(32'd4050, 0, 239, 1'b1, 1'b0));
		send_poll(lift_sample(32'd4170));
		send_poll(touch_sample(32'd5000, 239, 239, 1'b0, 1'b0));
		send_poll(touch_sample(32'd5050, 239, 0, 1'b1, 1'b0));
		send_poll(lift_sample(32'd5170));
		// long press, then a silent release
		send_poll(touch_sample(32'd6000, 120, 120, 1'b0, 1'b0));
		send_poll(touch_sample(32'd6400, 120, 120, 1'b1, 1'b0));
		send_poll(lift_sample(32'd6600));
		// hold with too much drift: no long press, swipe on release
		send_poll(touch_sample(32'd7000, 100, 100, 1'b0, 1'b0));
		send_poll(touch_sample(32'd7010, 150, 100, 1'b1, 1'b0));
		send_poll(touch_sample(32'd7500, 150, 100, 1'b1, 1'b0));
		send_poll(lift_sample(32'd7630));
		// tap across the time wrap, then an all-ones and an all-zeros poll
		send_poll(touch_sample(32'hFFFF_FFF0, 5, 5, 1'b0, 1'b0));
		send_poll(lift_sample(32'h0000_0070));
		send_poll('1);
		send_poll('0);
		settle();

		clock_ms = 32'd20000;
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: write_regs(400, 35, 40, 120, 20);
				1: write_regs(0, 0, 0, 0, 0);
				2: write_regs(65535, 511, 511, 65535, 65535);
				default: write_regs($urandom_range(0, 800), $urandom_range(0, 80),
					$urandom_range(0, 120), $urandom_range(0, 300), $urandom_range(0, 200));
			endcase
			if (phase == 3) begin
				clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
			end
			src_idle_pct = (phase == 0) ? 0 : $urandom_range(10, 50);
			sink_stall_pct = (phase == 0) ? 0 : $urandom_range(10, 50);
			phase_end = (phase + 1) * ITEM_TARGET / PHASES;
			while (polls_sent < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					send_poll(noise_sample(clock_ms));
				end
				run_gesture();
			end
			settle();
		end

		if (mismatches == 0 && gestures_due == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/tgc_pkg.sv
hw/rtl/tgc_if.sv
hw/rtl/tgc_sample.sv
hw/rtl/touch_gesture_classifier.sv
tb/sv/touch_gesture_checker.sv
tb/sv/touch_gesture_classifier_tb.sv
